### sv/pcci_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and control store for the clamped-integral PID controller.
package pcci_pkg;

    localparam int DATA_WIDTH_DEF = 16;
    localparam int SUM_WIDTH_DEF  = 24;

    localparam int GAIN_W   = 16;
    localparam int MAG_W    = 15;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_OUTPUT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_LIMIT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SETPOINT   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_RELATION   = 3'd7;

    localparam logic [MAG_W-1:0]  MAX_OUTPUT_RST = 15'd4096;
    localparam logic [MAG_W-1:0]  STEP_LIMIT_RST = 15'd41;  // 0.01 in Q4.12
    localparam logic [GAIN_W-1:0] RELATION_RST   = 16'd4096;

    typedef enum logic [1:0] {
        OP_COMPUTE    = 2'd0,
        OP_RESET      = 2'd1,
        OP_DONE_CHECK = 2'd2
    } op_t;

    typedef struct packed {
        logic [GAIN_W-1:0] gain_p;
        logic [GAIN_W-1:0] gain_i;
        logic [GAIN_W-1:0] gain_d;
        logic [MAG_W-1:0]  tolerance;
        logic [MAG_W-1:0]  max_output;
        logic [MAG_W-1:0]  step_limit;
        logic [GAIN_W-1:0] setpoint;
        logic [GAIN_W-1:0] relation;
    } cfg_t;

    localparam int UC_ADDR_W = 4;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_REL,
        MUL_P,
        MUL_I,
        MUL_D
    } mul_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_SUB
    } acc_op_t;

    typedef enum logic [1:0] {
        OUT_NONE,
        OUT_DRIVE,
        OUT_ZERO,
        OUT_DONE
    } out_sel_t;

    typedef enum logic {
        JMP_NONE,
        JMP_OUT_BAND
    } jmp_t;

    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } seq_state_t;

    typedef struct packed {
        mul_sel_t             mul_sel;
        acc_op_t              acc_op;
        logic                 err_load;
        logic                 sum_upd;
        logic                 commit;
        logic                 clear;
        out_sel_t             out_sel;
        jmp_t                 jmp;
        logic [UC_ADDR_W-1:0] jmp_addr;
    } ctrl_t;

    localparam logic [UC_ADDR_W-1:0] UC_COMPUTE = 4'd0;
    localparam logic [UC_ADDR_W-1:0] UC_RESET   = 4'd7;
    localparam logic [UC_ADDR_W-1:0] UC_CHECK   = 4'd8;
    localparam logic [UC_ADDR_W-1:0] UC_EMPTY   = 4'd10;

    function automatic ctrl_t ucode(input logic [UC_ADDR_W-1:0] addr);
        ctrl_t c;
        begin
            c = '0;
            case (addr)
                4'd0:
                begin
                    c.mul_sel = MUL_REL;
                end
                4'd1:
                begin
                    c.err_load = 1'b1;
                end
                4'd2:
                begin
                    c.mul_sel = MUL_P;
                    c.sum_upd = 1'b1;
                end
                4'd3:
                begin
                    c.mul_sel = MUL_I;
                    c.acc_op  = ACC_LOAD;
                end
                4'd4:
                begin
                    c.mul_sel = MUL_D;
                    c.acc_op  = ACC_ADD;
                end
                4'd5:
                begin
                    c.acc_op = ACC_SUB;
                    c.commit = 1'b1;
                end
                4'd6:
                begin
                    c.out_sel = OUT_DRIVE;
                end
                4'd7:
                begin
                    c.clear   = 1'b1;
                    c.out_sel = OUT_ZERO;
                end
                4'd8:
                begin
                    c.jmp      = JMP_OUT_BAND;
                    c.jmp_addr = UC_EMPTY;
                end
                4'd9:
                begin
                    c.clear   = 1'b1;
                    c.out_sel = OUT_DONE;
                end
                default:
                begin
                    c.out_sel = OUT_ZERO;
                end
            endcase
            return c;
        end
    endfunction

endpackage

### sv/pcci_sequencer.sv
`timescale 1ns / 1ps
// Microcode sequencer: step counter, dispatch by operation, conditional jump.
module pcci_sequencer (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic [1:0]       operation,
    input  logic             out_band,
    input  logic             out_ready,
    output logic             busy,
    output pcci_pkg::ctrl_t  ctrl
);

    pcci_pkg::seq_state_t                 state_reg, state_next;
    logic [pcci_pkg::UC_ADDR_W-1:0]       pc_reg, pc_next;
    pcci_pkg::ctrl_t                      rom_word;
    logic                                 emit_blocked;

    assign rom_word     = pcci_pkg::ucode(pc_reg);
    assign emit_blocked = (rom_word.out_sel != pcci_pkg::OUT_NONE) && !out_ready;
    assign busy         = (state_reg == pcci_pkg::SEQ_RUN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pcci_pkg::SEQ_IDLE;
            pc_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        ctrl       = '0;
        case (state_reg)
            pcci_pkg::SEQ_IDLE:
            begin
                if (accept)
                begin
                    state_next = pcci_pkg::SEQ_RUN;
                    case (operation)
                        pcci_pkg::OP_COMPUTE:    pc_next = pcci_pkg::UC_COMPUTE;
                        pcci_pkg::OP_RESET:      pc_next = pcci_pkg::UC_RESET;
                        pcci_pkg::OP_DONE_CHECK: pc_next = pcci_pkg::UC_CHECK;
                        default:                 pc_next = pcci_pkg::UC_EMPTY;
                    endcase
                end
            end
            pcci_pkg::SEQ_RUN:
            begin
                if (!emit_blocked)
                begin
                    ctrl = rom_word;
                    if (rom_word.out_sel != pcci_pkg::OUT_NONE)
                        state_next = pcci_pkg::SEQ_IDLE;
                    else if (rom_word.jmp == pcci_pkg::JMP_OUT_BAND && out_band)
                        pc_next = rom_word.jmp_addr;
                    else
                        pc_next = pc_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = pcci_pkg::SEQ_IDLE;
            end
        endcase
    end

endmodule

### sv/pcci_datapath.sv
`timescale 1ns / 1ps
// Datapath: shared multiplier, error, integral sum, accumulator and loop state.
module pcci_datapath #(
    parameter int DATA_WIDTH = pcci_pkg::DATA_WIDTH_DEF,
    parameter int SUM_WIDTH  = pcci_pkg::SUM_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  logic signed [DATA_WIDTH-1:0] measurement,
    input  pcci_pkg::cfg_t               cfg,
    input  pcci_pkg::ctrl_t              ctrl,
    output logic                         out_band,
    output logic        [DATA_WIDTH-1:0] drive_val
);

    localparam int DW     = DATA_WIDTH;
    localparam int SW     = SUM_WIDTH;
    localparam int DIFF_W = ((DW > 16) ? DW : 16) + 1;
    localparam int OPW    = (SW > DIFF_W) ? SW : DIFF_W;
    localparam int PW     = pcci_pkg::GAIN_W + OPW;
    localparam int ACC_W  = PW - 8 + 2;
    localparam int NSW    = ((SW > DIFF_W) ? SW : DIFF_W) + 1;
    localparam int MW     = ((DW + 1 > 17) ? DW + 1 : 17) + 1;

    localparam logic signed [PW-1:0]  ERR_MAX = {{(PW-DW+1){1'b0}}, {(DW-1){1'b1}}};
    localparam logic signed [PW-1:0]  ERR_MIN = ~ERR_MAX;
    localparam logic signed [NSW-1:0] SUM_MAX = {{(NSW-SW+1){1'b0}}, {(SW-1){1'b1}}};
    localparam logic signed [NSW-1:0] SUM_MIN = ~SUM_MAX;

    logic signed [DW-1:0]    meas_reg;
    logic signed [DW-1:0]    last_reg;
    logic                    first_reg;
    logic signed [SW-1:0]    sum_reg, sum_next;
    logic signed [DW-1:0]    err_reg, err_next;
    logic signed [PW-1:0]    prod_reg;
    logic signed [ACC_W-1:0] acc_reg, acc_next;

    logic signed [DIFF_W-1:0] diff;
    logic signed [DW:0]       dmeas;
    logic signed [15:0]       mul_a;
    logic signed [OPW-1:0]    mul_b;
    logic signed [PW-1:0]     prod;
    logic signed [PW-1:0]     err_sh;
    logic signed [PW-1:0]     term_sh;
    logic signed [ACC_W-1:0]  term;

    logic signed [DIFF_W-1:0] err_c, tol_c, step_c, inc;
    logic signed [NSW-1:0]    sum_c, base, ns;

    logic signed [ACC_W-1:0]  mo, total;
    logic signed [MW-1:0]     mag, bound;

    // multiplier operand select
    assign diff  = DIFF_W'(signed'(cfg.setpoint)) - DIFF_W'(meas_reg);
    assign dmeas = first_reg ? '0 : ((DW+1)'(meas_reg) - (DW+1)'(last_reg));

    always_comb
    begin
        case (ctrl.mul_sel)
            pcci_pkg::MUL_REL:
            begin
                mul_a = signed'(cfg.relation);
                mul_b = OPW'(diff);
            end
            pcci_pkg::MUL_P:
            begin
                mul_a = signed'(cfg.gain_p);
                mul_b = OPW'(err_reg);
            end
            pcci_pkg::MUL_I:
            begin
                mul_a = signed'(cfg.gain_i);
                mul_b = OPW'(sum_reg);
            end
            pcci_pkg::MUL_D:
            begin
                mul_a = signed'(cfg.gain_d);
                mul_b = OPW'(dmeas);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // error: floor(diff * relation / 2^12), saturated
    always_comb
    begin
        err_sh = prod_reg >>> 12;
        if (err_sh > ERR_MAX)
            err_next = ERR_MAX[DW-1:0];
        else if (err_sh < ERR_MIN)
            err_next = ERR_MIN[DW-1:0];
        else
            err_next = err_sh[DW-1:0];
    end

    // integral update
    always_comb
    begin
        err_c  = DIFF_W'(err_reg);
        tol_c  = DIFF_W'(signed'({1'b0, cfg.tolerance}));
        step_c = DIFF_W'(signed'({1'b0, cfg.step_limit}));
        sum_c  = NSW'(sum_reg);
        if (err_c >= tol_c)
        begin
            base = (sum_c < 0) ? '0 : sum_c;
            inc  = (err_c < step_c) ? err_c : step_c;
        end
        else if (err_c <= -tol_c)
        begin
            base = (sum_c > 0) ? '0 : sum_c;
            inc  = (err_c > -step_c) ? err_c : -step_c;
        end
        else
        begin
            base = '0;
            inc  = '0;
        end
        ns = base + NSW'(inc);
        if (ns > SUM_MAX)
            sum_next = SUM_MAX[SW-1:0];
        else if (ns < SUM_MIN)
            sum_next = SUM_MIN[SW-1:0];
        else
            sum_next = ns[SW-1:0];
    end

    // term accumulation
    always_comb
    begin
        term_sh = prod_reg >>> 8;
        term    = ACC_W'(signed'(term_sh[PW-9:0]));
        case (ctrl.acc_op)
            pcci_pkg::ACC_LOAD: acc_next = term;
            pcci_pkg::ACC_ADD:  acc_next = acc_reg + term;
            pcci_pkg::ACC_SUB:  acc_next = acc_reg - term;
            default:            acc_next = acc_reg;
        endcase
    end

    // output clamp
    always_comb
    begin
        mo = ACC_W'(signed'({1'b0, cfg.max_output}));
        if (acc_reg > mo)
            total = mo;
        else if (acc_reg < -mo)
            total = -mo;
        else
            total = acc_reg;
    end

    assign drive_val = total[DW-1:0];

    // done-check band
    assign mag      = (meas_reg < 0) ? -MW'(meas_reg) : MW'(meas_reg);
    assign bound    = MW'(signed'(cfg.setpoint)) + MW'(signed'({1'b0, cfg.tolerance}));
    assign out_band = (mag > bound);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg  <= '0;
            sum_reg   <= '0;
            first_reg <= 1'b1;
        end
        else
        begin
            if (ctrl.clear)
            begin
                last_reg  <= '0;
                sum_reg   <= '0;
                first_reg <= 1'b1;
            end
            else
            begin
                if (ctrl.sum_upd)
                    sum_reg <= sum_next;
                if (ctrl.commit)
                begin
                    last_reg  <= meas_reg;
                    first_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            meas_reg <= measurement;
        if (ctrl.err_load)
            err_reg <= err_next;
        if (ctrl.mul_sel != pcci_pkg::MUL_NONE)
            prod_reg <= prod;
        acc_reg <= acc_next;
    end

endmodule

### sv/pid_controller_clamped_integral.sv
`timescale 1ns / 1ps
// Top level of the clamped-integral PID controller: registers, output stage, assertions.
//
//  channel  signals                          direction
//  in       in_valid/in_stall, operation,    request into block
//           measurement
//  out      out_valid/out_stall, drive,      request out of block
//           done_res
//  cfg      cfg_we, cfg_index, cfg_data      register write, no stall
//
// One request at a time. A compute request runs the longest microcode program
// through the single shared multiplier; a reset request, a done check and an unused
// code run shorter ones. Input stalls while the
// program runs. A finished result waits in the output register; the last step
// holds while that register is full and out_stall is high. Reset is asynchronous, active low.
module pid_controller_clamped_integral #(
    parameter int DATA_WIDTH = pcci_pkg::DATA_WIDTH_DEF,
    parameter int SUM_WIDTH  = pcci_pkg::SUM_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [1:0]                          operation,
    input  logic signed [DATA_WIDTH-1:0]        measurement,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [DATA_WIDTH-1:0]        drive,
    output logic                                done_res,
    input  logic                                cfg_we,
    input  logic [pcci_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pcci_pkg::CFG_W-1:0]          cfg_data
);

    pcci_pkg::cfg_t         cfg_reg;
    pcci_pkg::ctrl_t        ctrl;
    logic                   accept;
    logic                   busy;
    logic                   out_band;
    logic                   out_ready;
    logic [DATA_WIDTH-1:0]  drive_val;
    logic                   out_valid_reg;
    logic [DATA_WIDTH-1:0]  drive_reg;
    logic                   done_reg;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = busy;
    assign out_ready = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_p     <= '0;
            cfg_reg.gain_i     <= '0;
            cfg_reg.gain_d     <= '0;
            cfg_reg.tolerance  <= '0;
            cfg_reg.max_output <= pcci_pkg::MAX_OUTPUT_RST;
            cfg_reg.step_limit <= pcci_pkg::STEP_LIMIT_RST;
            cfg_reg.setpoint   <= '0;
            cfg_reg.relation   <= pcci_pkg::RELATION_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pcci_pkg::REG_GAIN_P:     cfg_reg.gain_p     <= cfg_data;
                pcci_pkg::REG_GAIN_I:     cfg_reg.gain_i     <= cfg_data;
                pcci_pkg::REG_GAIN_D:     cfg_reg.gain_d     <= cfg_data;
                pcci_pkg::REG_TOLERANCE:  cfg_reg.tolerance  <= cfg_data[pcci_pkg::MAG_W-1:0];
                pcci_pkg::REG_MAX_OUTPUT: cfg_reg.max_output <= cfg_data[pcci_pkg::MAG_W-1:0];
                pcci_pkg::REG_STEP_LIMIT: cfg_reg.step_limit <= cfg_data[pcci_pkg::MAG_W-1:0];
                pcci_pkg::REG_SETPOINT:   cfg_reg.setpoint   <= cfg_data;
                pcci_pkg::REG_RELATION:   cfg_reg.relation   <= cfg_data;
                default:                  cfg_reg            <= cfg_reg;
            endcase
        end
    end

    pcci_sequencer u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .operation (operation),
        .out_band  (out_band),
        .out_ready (out_ready),
        .busy      (busy),
        .ctrl      (ctrl)
    );

    pcci_datapath #(
        .DATA_WIDTH (DATA_WIDTH),
        .SUM_WIDTH  (SUM_WIDTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .measurement (measurement),
        .cfg         (cfg_reg),
        .ctrl        (ctrl),
        .out_band    (out_band),
        .drive_val   (drive_val)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ctrl.out_sel != pcci_pkg::OUT_NONE)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        case (ctrl.out_sel)
            pcci_pkg::OUT_DRIVE:
            begin
                drive_reg <= drive_val;
                done_reg  <= 1'b0;
            end
            pcci_pkg::OUT_ZERO:
            begin
                drive_reg <= '0;
                done_reg  <= 1'b0;
            end
            pcci_pkg::OUT_DONE:
            begin
                drive_reg <= '0;
                done_reg  <= 1'b1;
            end
            default:
            begin
                drive_reg <= drive_reg;
                done_reg  <= done_reg;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign drive     = signed'(drive_reg);
    assign done_res  = done_reg;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> in_stall)
        else $error("block not busy after accepting a request");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.out_sel != pcci_pkg::OUT_NONE) |-> (!out_valid_reg || !out_stall))
        else $error("pending result overwritten");

    a_done_zero_drive: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && done_res) |-> (drive == '0))
        else $error("done result with nonzero drive");

    a_emit_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.out_sel != pcci_pkg::OUT_NONE) |-> busy)
        else $error("result emitted while idle");

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the clamped-integral PID controller: queued driver, monitor, predictor.
module tb;
    import pcci_pkg::*;

    localparam int          IDLE_PCT    = 18;
    localparam int          CYCLE_LIMIT = 200000;
    localparam logic [1:0]  OP_UNUSED   = 2'd3;
    localparam longint      DATA_HI     = 32767;
    localparam longint      DATA_LO     = -32768;
    localparam longint      SUM_HI      = 8388607;
    localparam longint      SUM_LO      = -8388608;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] meas;
    } sample_t;

    typedef struct packed {
        logic [15:0] drive;
        logic        done;
    } pid_out_t;

    logic                 clk;
    logic                 rst_n       = 1'b0;
    logic                 in_valid    = 1'b0;
    logic                 in_stall;
    logic [1:0]           operation   = OP_COMPUTE;
    logic signed [15:0]   measurement = '0;
    logic                 out_valid;
    logic                 out_stall   = 1'b0;
    logic signed [15:0]   drive;
    logic                 done_res;
    logic                 cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index   = REG_GAIN_P;
    logic [CFG_W-1:0]     cfg_data    = '0;

    sample_t  sample_q[$];
    pid_out_t pid_q[$];
    sample_t  drv_req;
    pid_out_t mon_exp;
    cfg_t     cfg_shadow;
    longint   last_meas    = 0;
    longint   err_sum      = 0;
    bit       first_sample = 1'b1;
    bit       no_idle      = 1'b0;
    int       fail_count   = 0;
    int       cycle_count  = 0;

    pid_controller_clamped_integral u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .measurement (measurement),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .drive       (drive),
        .done_res    (done_res),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic pid_out_t pid_compute(input logic [1:0] op, input logic [15:0] meas);
        pid_out_t res;
        longint   m;
        longint   prev;
        longint   err;
        longint   s;
        longint   tol;
        longint   lim;
        longint   mx;
        longint   p_t;
        longint   i_t;
        longint   d_t;
        longint   total;
        longint   mag;
        res = '0;
        m   = longint'($signed(meas));
        tol = longint'(cfg_shadow.tolerance);
        lim = longint'(cfg_shadow.step_limit);
        mx  = longint'(cfg_shadow.max_output);
        if (op == OP_COMPUTE)
        begin
            prev = first_sample ? m : last_meas;
            err  = ((longint'($signed(cfg_shadow.setpoint)) - m)
                    * longint'($signed(cfg_shadow.relation))) >>> 12;
            if (err > DATA_HI)
                err = DATA_HI;
            else if (err < DATA_LO)
                err = DATA_LO;
            s = err_sum;
            if (err >= tol)
            begin
                if (s < 0)
                    s = 0;
                s = s + ((err < lim) ? err : lim);
            end
            else if (err <= -tol)
            begin
                if (s > 0)
                    s = 0;
                s = s + ((err > -lim) ? err : -lim);
            end
            else
                s = 0;
            if (s > SUM_HI)
                s = SUM_HI;
            else if (s < SUM_LO)
                s = SUM_LO;
            err_sum = s;
            p_t = (longint'($signed(cfg_shadow.gain_p)) * err) >>> 8;
            i_t = (longint'($signed(cfg_shadow.gain_i)) * err_sum) >>> 8;
            d_t = (longint'($signed(cfg_shadow.gain_d)) * (m - prev)) >>> 8;
            total = p_t + i_t - d_t;
            if (total > mx)
                total = mx;
            else if (total < -mx)
                total = -mx;
            res.drive    = total[15:0];
            last_meas    = m;
            first_sample = 1'b0;
        end
        else if (op == OP_RESET)
        begin
            last_meas    = 0;
            err_sum      = 0;
            first_sample = 1'b1;
        end
        else if (op == OP_DONE_CHECK)
        begin
            mag = (m < 0) ? -m : m;
            if (mag <= longint'($signed(cfg_shadow.setpoint)) + tol)
            begin
                last_meas    = 0;
                err_sum      = 0;
                first_sample = 1'b1;
                res.done     = 1'b1;
            end
        end
        return res;
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                pid_q.push_back(pid_compute(operation, measurement));
            if (!in_valid || !in_stall)
            begin
                if (sample_q.size() > 0 && (no_idle || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    drv_req     = sample_q.pop_front();
                    in_valid    <= 1'b1;
                    operation   <= drv_req.op;
                    measurement <= drv_req.meas;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pid_q.size() == 0)
                begin
                    $display("%0t: unexpected result drive %0d done_res %0b",
                             $time, drive, done_res);
                    fail_count++;
                end
                else
                begin
                    mon_exp = pid_q.pop_front();
                    if (drive !== mon_exp.drive)
                    begin
                        $display("%0t: drive expected %0d actual %0d",
                                 $time, $signed(mon_exp.drive), drive);
                        fail_count++;
                    end
                    if (done_res !== mon_exp.done)
                    begin
                        $display("%0t: done_res expected %0b actual %0b",
                                 $time, mon_exp.done, done_res);
                        fail_count++;
                    end
                end
            end
            out_stall <= !no_idle && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_GAIN_P:     cfg_shadow.gain_p     = val;
            REG_GAIN_I:     cfg_shadow.gain_i     = val;
            REG_GAIN_D:     cfg_shadow.gain_d     = val;
            REG_TOLERANCE:  cfg_shadow.tolerance  = val[14:0];
            REG_MAX_OUTPUT: cfg_shadow.max_output = val[14:0];
            REG_STEP_LIMIT: cfg_shadow.step_limit = val[14:0];
            REG_SETPOINT:   cfg_shadow.setpoint   = val;
            default:        cfg_shadow.relation   = val;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_config(input logic [15:0] gp, input logic [15:0] gi,
                               input logic [15:0] gd, input logic [15:0] tol,
                               input logic [15:0] mx, input logic [15:0] lim,
                               input logic [15:0] sp, input logic [15:0] rel);
        repeat (8) @(posedge clk);
        write_reg(REG_GAIN_P, gp);
        write_reg(REG_GAIN_I, gi);
        write_reg(REG_GAIN_D, gd);
        write_reg(REG_TOLERANCE, tol);
        write_reg(REG_MAX_OUTPUT, mx);
        write_reg(REG_STEP_LIMIT, lim);
        write_reg(REG_SETPOINT, sp);
        write_reg(REG_RELATION, rel);
        @(negedge clk);
    endtask

    task automatic drain();
        @(negedge clk);
        while (sample_q.size() != 0 || in_valid || pid_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic queue_req(input logic [1:0] op, input logic [15:0] meas);
        sample_t r;
        r.op   = op;
        r.meas = meas;
        sample_q.push_back(r);
    endtask

    function automatic logic [15:0] pick_ext(input logic [15:0] normal);
        int r;
        r = $urandom_range(0, 99);
        if (r < 4)
            return 16'h8000;
        if (r < 8)
            return 16'h7FFF;
        if (r < 12)
            return 16'h0000;
        if (r < 15)
            return 16'hFFFF;
        return normal;
    endfunction

    function automatic logic [15:0] random_meas();
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (r < 50)
            v = int'($signed(cfg_shadow.setpoint)) + $urandom_range(0, 1024) - 512;
        else if (r < 90)
            v = $urandom_range(0, 65535);
        else
            v = ($urandom_range(0, 1) != 0) ? 32767 : -32768;
        return v[15:0];
    endfunction

    task automatic queue_random(input int n);
        int r;
        logic [1:0] op;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 78)
                op = OP_COMPUTE;
            else if (r < 86)
                op = OP_DONE_CHECK;
            else if (r < 94)
                op = OP_RESET;
            else
                op = OP_UNUSED;
            queue_req(op, random_meas());
        end
    endtask

    task automatic random_config();
        int v;
        logic [15:0] gp;
        logic [15:0] gi;
        logic [15:0] gd;
        logic [15:0] tol;
        logic [15:0] mx;
        logic [15:0] lim;
        logic [15:0] sp;
        logic [15:0] rel;
        v   = $urandom_range(0, 2048) - 1024;
        gp  = pick_ext(v[15:0]);
        v   = $urandom_range(0, 512) - 256;
        gi  = pick_ext(v[15:0]);
        v   = $urandom_range(0, 2048) - 1024;
        gd  = pick_ext(v[15:0]);
        v   = $urandom_range(0, 800) | ($urandom_range(0, 1) << 15);
        tol = pick_ext(v[15:0]);
        v   = $urandom_range(1000, 32767);
        mx  = pick_ext(v[15:0]);
        v   = $urandom_range(0, 2000) | ($urandom_range(0, 1) << 15);
        lim = pick_ext(v[15:0]);
        v   = $urandom_range(0, 16384) - 8192;
        sp  = pick_ext(v[15:0]);
        v   = $urandom_range(0, 8192);
        rel = pick_ext(v[15:0]);
        load_config(gp, gi, gd, tol, mx, lim, sp, rel);
    endtask

    initial
    begin
        cfg_shadow            = '0;
        cfg_shadow.max_output = MAX_OUTPUT_RST;
        cfg_shadow.step_limit = STEP_LIMIT_RST;
        cfg_shadow.relation   = RELATION_RST;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset values of the registers
        queue_req(OP_COMPUTE, 16'd4096);
        queue_req(OP_COMPUTE, 16'hF000);
        queue_req(OP_DONE_CHECK, 16'd1);
        queue_req(OP_DONE_CHECK, 16'd0);
        queue_req(OP_UNUSED, 16'hFFFF);
        queue_req(OP_RESET, 16'h0000);
        drain();

        // directed: band edges, integral sign drop, first sample, done check
        load_config(16'd256, 16'd256, 16'd256, 16'd64, 16'h7FFF, 16'd41, 16'd4096, 16'd4096);
        queue_req(OP_COMPUTE, 16'd4096);
        queue_req(OP_COMPUTE, 16'd0);
        queue_req(OP_COMPUTE, 16'd0);
        queue_req(OP_COMPUTE, 16'h7FFF);
        queue_req(OP_COMPUTE, 16'h8000);
        queue_req(OP_COMPUTE, 16'd4128);
        queue_req(OP_COMPUTE, 16'd4032);
        queue_req(OP_COMPUTE, 16'd4160);
        queue_req(OP_UNUSED, 16'h5555);
        queue_req(OP_RESET, 16'h0000);
        queue_req(OP_COMPUTE, 16'd1000);
        queue_req(OP_DONE_CHECK, 16'd5000);
        queue_req(OP_DONE_CHECK, 16'hEFFC);
        queue_req(OP_COMPUTE, 16'd2000);
        queue_req(OP_DONE_CHECK, 16'd4160);
        queue_req(OP_DONE_CHECK, 16'h7FFF);
        queue_req(OP_DONE_CHECK, 16'h8000);
        queue_req(OP_COMPUTE, 16'hAAAA);
        queue_req(OP_COMPUTE, 16'h5555);
        queue_req(OP_UNUSED, 16'hAAAA);
        queue_req(OP_RESET, 16'hFFFF);
        drain();

        // register extremes; zero tolerance with zero error
        load_config(16'h7FFF, 16'h8000, 16'h7FFF, 16'h0000, 16'h7FFF, 16'h7FFF,
                    16'h8000, 16'h8000);
        queue_req(OP_COMPUTE, 16'h8000);
        queue_req(OP_COMPUTE, 16'h8000);
        queue_req(OP_COMPUTE, 16'h7FFF);
        queue_random(8);
        queue_req(OP_DONE_CHECK, 16'h8000);
        drain();
        load_config(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h0000, 16'h0000,
                    16'h7FFF, 16'h7FFF);
        queue_req(OP_COMPUTE, 16'h8000);
        queue_req(OP_COMPUTE, 16'h7FFF);
        queue_random(9);
        queue_req(OP_DONE_CHECK, 16'h7FFF);
        drain();

        // drive the integral into both saturation limits, no idling
        no_idle = 1'b1;
        load_config(16'h0000, 16'h0001, 16'h0002, 16'h0000, 16'h7FFF, 16'h7FFF,
                    16'h0000, 16'h7FFF);
        for (int i = 0; i < 270; i++)
            queue_req(OP_COMPUTE, 16'h8000 + 16'($urandom_range(0, 255)));
        for (int i = 0; i < 270; i++)
            queue_req(OP_COMPUTE, 16'h7FFF - 16'($urandom_range(0, 255)));
        drain();
        no_idle = 1'b0;

        for (int p = 0; p < 6; p++)
        begin
            random_config();
            queue_random(45);
            drain();
            queue_random(45);
            drain();
        end

        repeat (20) @(posedge clk);
        if (fail_count == 0 && pid_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
